@@ rtl/cba_pkg.sv @@
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and fixed constants of the centered box average filter.
// ----------------------------------------------------------------------------
`default_nettype none

package cba_pkg;

  // Width of the half width configuration register.
  localparam int CFG_HW_BITS = 5;

  // Depth of the queue between the front and the back, and its pointer width.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  // Front: takes an item, updates the running sum, then flushes at row end.
  typedef enum logic [1:0] {
    FS_IDLE,
    FS_UPDATE,
    FS_FLUSH
  } front_state_t;

  // Back: pops a window sum, divides it, holds the result for the receiver.
  typedef enum logic [1:0] {
    BS_IDLE,
    BS_DIVIDE,
    BS_HOLD
  } back_state_t;

endpackage : cba_pkg

`default_nettype wire

@@ rtl/cba_front.sv @@
// ----------------------------------------------------------------------------
// cba_front
// Accepts samples, keeps the sample ring and the running window sum, and
// pushes one window sum per position that is due, with the row's last mark.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_front #(
  parameter int SAMPLE_BITS = 16,
  parameter int HW          = 5,
  parameter int AW          = 6,
  parameter int RCW         = 6,
  parameter int SW          = 22
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  input  wire logic                   in_row_end,
  input  wire logic [HW-1:0]          half_w,
  input  wire logic [AW-1:0]          win_len,
  output logic                        push_valid,
  input  wire logic                   push_full,
  output logic [SW-1:0]               push_sum,
  output logic                        push_last
);
  import cba_pkg::*;

  localparam int RING_DEPTH = 1 << AW;

  front_state_t state_r, state_nxt;

  logic [SAMPLE_BITS-1:0] smp_r, smp_nxt;
  logic                   last_r, last_nxt;
  logic [AW-1:0]          wp_r, wp_nxt;
  logic [AW-1:0]          cnt_r, cnt_nxt;
  logic [RCW-1:0]         rowc_r, rowc_nxt;
  logic [SW-1:0]          sum_r, sum_nxt;
  logic [HW-1:0]          idx_r, idx_nxt;

  logic [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];
  logic [SAMPLE_BITS-1:0] rdata_r;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   wr_en;

  logic [RCW-1:0]         h_ext;
  logic [SW-1:0]          smp_ext;
  logic [SW-1:0]          old_ext;
  logic [SW-1:0]          sum_upd;
  logic [SW-1:0]          sum_flush;
  logic [AW-1:0]          back_dist;
  logic                   upd_old_ok;
  logic                   flush_old_ok;
  logic                   emit_upd;
  logic                   emit_flush;
  logic [RCW:0]           idx_plus_rowc;

  // Arithmetic shared by the update and flush steps.
  always_comb begin
    h_ext         = RCW'(half_w);
    smp_ext       = {{AW{smp_r[SAMPLE_BITS-1]}}, smp_r};
    old_ext       = {{AW{rdata_r[SAMPLE_BITS-1]}}, rdata_r};
    // An entry is valid only if it was written earlier in this row.
    upd_old_ok    = (cnt_r >= win_len);
    back_dist     = win_len - AW'(idx_r);
    flush_old_ok  = (cnt_r >= back_dist);
    sum_upd       = sum_r + smp_ext - (upd_old_ok ? old_ext : '0);
    sum_flush     = sum_r - (flush_old_ok ? old_ext : '0);
    emit_upd      = (rowc_r >= h_ext);
    idx_plus_rowc = (RCW+1)'(idx_r) + (RCW+1)'(rowc_r);
    emit_flush    = (rowc_r >= h_ext) || (idx_plus_rowc >= (RCW+1)'(half_w));
  end

  // Next state and handshake.
  always_comb begin
    state_nxt  = state_r;
    smp_nxt    = smp_r;
    last_nxt   = last_r;
    wp_nxt     = wp_r;
    cnt_nxt    = cnt_r;
    rowc_nxt   = rowc_r;
    sum_nxt    = sum_r;
    idx_nxt    = idx_r;
    in_stall   = 1'b1;
    push_valid = 1'b0;
    push_last  = 1'b0;
    push_sum   = sum_upd;
    rd_en      = 1'b0;
    rd_addr    = wp_r - win_len;
    wr_en      = 1'b0;

    case (state_r)
      FS_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          wr_en     = 1'b1;
          rd_en     = 1'b1;
          smp_nxt   = in_sample;
          last_nxt  = in_row_end;
          state_nxt = FS_UPDATE;
        end
      end

      FS_UPDATE: begin
        push_sum = sum_upd;
        if (!(emit_upd && push_full)) begin
          push_valid = emit_upd;
          push_last  = last_r && (half_w == '0);
          if (last_r) begin
            if (half_w == '0) begin
              sum_nxt   = '0;
              wp_nxt    = '0;
              cnt_nxt   = '0;
              rowc_nxt  = '0;
              state_nxt = FS_IDLE;
            end else begin
              sum_nxt   = sum_upd;
              idx_nxt   = HW'(1);
              rd_en     = 1'b1;
              rd_addr   = wp_r - win_len + AW'(1);
              state_nxt = FS_FLUSH;
            end
          end else begin
            sum_nxt = sum_upd;
            wp_nxt  = wp_r + AW'(1);
            if (cnt_r != '1) begin
              cnt_nxt = cnt_r + AW'(1);
            end
            if (rowc_r < h_ext + RCW'(1)) begin
              rowc_nxt = rowc_r + RCW'(1);
            end
            state_nxt = FS_IDLE;
          end
        end
      end

      FS_FLUSH: begin
        push_sum = sum_flush;
        if (!(emit_flush && push_full)) begin
          push_valid = emit_flush;
          push_last  = (idx_r == half_w);
          if (idx_r == half_w) begin
            sum_nxt   = '0;
            wp_nxt    = '0;
            cnt_nxt   = '0;
            rowc_nxt  = '0;
            state_nxt = FS_IDLE;
          end else begin
            sum_nxt = sum_flush;
            idx_nxt = idx_r + HW'(1);
            rd_en   = 1'b1;
            rd_addr = wp_r - win_len + AW'(idx_r) + AW'(1);
          end
        end
      end

      default: begin
        state_nxt = FS_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      wp_r    <= '0;
      cnt_r   <= '0;
      rowc_r  <= '0;
      sum_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      cnt_r   <= cnt_nxt;
      rowc_r  <= rowc_nxt;
      sum_r   <= sum_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    smp_r  <= smp_nxt;
    last_r <= last_nxt;
  end

  // Sample ring: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wp_r] <= in_sample;
    end
    if (rd_en) begin
      rdata_r <= ring_mem[rd_addr];
    end
  end

endmodule : cba_front

`default_nettype wire

@@ rtl/cba_queue.sv @@
// ----------------------------------------------------------------------------
// cba_queue
// Small first-in first-out queue of window sums between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_queue #(
  parameter int WIDTH = 23
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  not_empty
);
  import cba_pkg::*;

  logic [WIDTH-1:0]  data_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;
  logic                do_push;
  logic                do_pop;

  // Status and read side.
  always_comb begin
    full      = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
    not_empty = (count_r != '0);
    do_push   = push && !full;
    do_pop    = pop && not_empty;
    pop_data  = data_r[rd_ptr_r];
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QUEUE_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (QUEUE_AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (QUEUE_AW+1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= push_data;
    end
  end

endmodule : cba_queue

`default_nettype wire

@@ rtl/cba_divider.sv @@
// ----------------------------------------------------------------------------
// cba_divider
// Back end: divides each window sum by the window length, one quotient bit
// per cycle, truncating toward zero, and holds the result for the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module cba_divider #(
  parameter int SAMPLE_BITS = 16,
  parameter int AW          = 6,
  parameter int SW          = 22
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_valid,
  output logic                        q_pop,
  input  wire logic [SW-1:0]          q_sum,
  input  wire logic                   q_last,
  input  wire logic [AW-1:0]          win_len,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [SAMPLE_BITS-1:0]      out_average,
  output logic                        out_row_last
);
  import cba_pkg::*;

  localparam int CW = $clog2(SW);

  back_state_t state_r, state_nxt;

  logic [SW-1:0]          mag_r, mag_nxt;
  logic [AW-1:0]          rem_r, rem_nxt;
  logic [CW-1:0]          ctr_r, ctr_nxt;
  logic                   neg_r, neg_nxt;
  logic                   last_r, last_nxt;
  logic [SAMPLE_BITS-1:0] avg_r, avg_nxt;

  logic [AW:0]            rem_sh;
  logic                   q_bit;
  logic [SW-1:0]          quot;

  // One restoring division step.
  always_comb begin
    rem_sh = {rem_r, mag_r[SW-1]};
    q_bit  = (rem_sh >= (AW+1)'(win_len));
    quot   = {mag_r[SW-2:0], q_bit};
  end

  // Next state and handshake.
  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    rem_nxt   = rem_r;
    ctr_nxt   = ctr_r;
    neg_nxt   = neg_r;
    last_nxt  = last_r;
    avg_nxt   = avg_r;
    q_pop     = 1'b0;
    out_valid = 1'b0;

    case (state_r)
      BS_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          neg_nxt   = q_sum[SW-1];
          mag_nxt   = q_sum[SW-1] ? (~q_sum + SW'(1)) : q_sum;
          rem_nxt   = '0;
          ctr_nxt   = CW'(SW - 1);
          last_nxt  = q_last;
          state_nxt = BS_DIVIDE;
        end
      end

      BS_DIVIDE: begin
        rem_nxt = q_bit ? AW'(rem_sh - (AW+1)'(win_len)) : AW'(rem_sh);
        mag_nxt = quot;
        ctr_nxt = ctr_r - CW'(1);
        if (ctr_r == '0) begin
          avg_nxt   = neg_r ? SAMPLE_BITS'(~quot + SW'(1)) : SAMPLE_BITS'(quot);
          state_nxt = BS_HOLD;
        end
      end

      BS_HOLD: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = BS_IDLE;
        end
      end

      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  // Control register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    rem_r  <= rem_nxt;
    ctr_r  <= ctr_nxt;
    neg_r  <= neg_nxt;
    last_r <= last_nxt;
    avg_r  <= avg_nxt;
  end

  assign out_average  = avg_r;
  assign out_row_last = last_r;

endmodule : cba_divider

`default_nettype wire

@@ rtl/centered_box_average_filter.sv @@
// ----------------------------------------------------------------------------
// centered_box_average_filter
// Centered moving average over rows of signed samples, zero padded at both
// row ends, divided by the window length and truncated toward zero.
//
// Usage: one sample per input item, with in_row_end on the last sample of a
// row. The window holds 2*H+1 samples, H written through the cfg channel
// (cfg_ready is always high; write only while the block is idle). Position p
// of a row comes out when sample p+H arrives; the row's last sample flushes
// the remaining positions, and out_row_last marks the row's final result.
// The front takes an item in its idle and update states and, at a row end,
// spends a flush step on each remaining position with one ring read per
// step, holding while the queue is full. The back divides one bit per cycle;
// that divider sets the sustained result rate. A 4-entry queue lets the
// front keep taking items while the back divides. When out_stall is high the
// result holds, the queue fills and then in_stall rises. Reset clears the
// running sum, pointers and counters and sets H to 0; no clearing pass is
// needed.
// ----------------------------------------------------------------------------
`default_nettype none

module centered_box_average_filter #(
  parameter int MAX_HALF_WIDTH = 31,
  parameter int SAMPLE_BITS    = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]     in_sample,
  input  wire logic                              in_row_end,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]          out_average,
  output logic                                   out_row_last,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [cba_pkg::CFG_HW_BITS-1:0]   cfg_half_width
);
  import cba_pkg::*;

  localparam int HW  = $clog2(MAX_HALF_WIDTH + 1);
  localparam int AW  = $clog2(2 * MAX_HALF_WIDTH + 2);
  localparam int RCW = $clog2(MAX_HALF_WIDTH + 2);
  localparam int SW  = SAMPLE_BITS + AW;

  logic [CFG_HW_BITS-1:0] hw_cfg_r;
  logic [HW-1:0]          half_w;
  logic [AW-1:0]          win_len;

  logic                   push_valid;
  logic                   push_full;
  logic [SW-1:0]          push_sum;
  logic                   push_last;
  logic                   q_pop;
  logic [SW:0]            q_data;
  logic                   q_valid;
  logic [SAMPLE_BITS-1:0] avg_bits;

  // Configuration register, always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      hw_cfg_r <= cfg_half_width;
    end
  end

  // Effective half width is capped at the largest supported value.
  always_comb begin
    if (hw_cfg_r > CFG_HW_BITS'(MAX_HALF_WIDTH)) begin
      half_w = HW'(MAX_HALF_WIDTH);
    end else begin
      half_w = HW'(hw_cfg_r);
    end
    win_len = AW'({half_w, 1'b1});
  end

  cba_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .HW          (HW),
    .AW          (AW),
    .RCW         (RCW),
    .SW          (SW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .in_row_end (in_row_end),
    .half_w     (half_w),
    .win_len    (win_len),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_sum   (push_sum),
    .push_last  (push_last)
  );

  cba_queue #(
    .WIDTH (SW + 1)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_valid),
    .push_data ({push_last, push_sum}),
    .full      (push_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid)
  );

  cba_divider #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .AW          (AW),
    .SW          (SW)
  ) u_divider (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_sum        (q_data[SW-1:0]),
    .q_last       (q_data[SW]),
    .win_len      (win_len),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_average  (avg_bits),
    .out_row_last (out_row_last)
  );

  assign out_average = avg_bits;

endmodule : centered_box_average_filter

`default_nettype wire
